FILE: rtl/ust_pkg.sv
package ust_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 11;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MEMBER = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request, restart scan
    logic scan;       // walk stored entries
    logic append;     // insert miss: write at end or flag drop
    logic read_last;  // delete hit: fetch last entry
    logic move;       // delete hit: last entry into hit slot
    logic emit;       // load output register
  } ust_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic              match;     // compared entry equals value
    logic              scan_end;  // all entries compared, no match
    logic [FUNC_W-1:0] op;
    logic              out_free;  // output register can take a result
  } ust_sts_t;

endpackage

FILE: rtl/ust_req_if.sv
interface ust_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [ust_pkg::FUNC_W-1:0]           func;
  logic signed [ust_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

FILE: rtl/ust_rsp_if.sv
interface ust_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [ust_pkg::COUNT_W-1:0]  count;
  logic                         dropped;

  modport source (output valid, output found, output count, output dropped, input ready);
  modport sink (input valid, input found, input count, input dropped, output ready);
endinterface

FILE: rtl/ust_ctrl.sv
module ust_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ust_pkg::ust_sts_t sts_i,
  output ust_pkg::ust_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_MOVE  = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.match) begin
          state_d = (sts_i.op == ust_pkg::FUNC_DELETE) ? ST_FETCH : ST_RESP;
        end else if (sts_i.scan_end) begin
          cmd_o.append = (sts_i.op == ust_pkg::FUNC_INSERT);
          state_d      = ST_RESP;
        end
      end
      ST_FETCH: begin
        cmd_o.read_last = 1'b1;
        state_d         = ST_MOVE;
      end
      ST_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/ust_datapath.sv
module ust_datapath #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ust_pkg::ust_cmd_t                  cmd_i,
  output ust_pkg::ust_sts_t                  sts_o,
  input  logic [ust_pkg::FUNC_W-1:0]         in_func_i,
  input  logic signed [ust_pkg::VALUE_W-1:0] in_value_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_found_o,
  output logic [ust_pkg::COUNT_W-1:0]        out_count_o,
  output logic                               out_dropped_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [ust_pkg::VALUE_W-1:0] mem [CAPACITY];

  logic [ust_pkg::FUNC_W-1:0]  op_q;
  logic [ust_pkg::VALUE_W-1:0] val_q;
  logic [ust_pkg::VALUE_W-1:0] rdata_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [CNT_W-1:0]            idx_q;
  logic [IDX_W-1:0]            cmp_idx_q;
  logic                        cmp_vld_q;
  logic [IDX_W-1:0]            slot_q;
  logic                        hit_q;
  logic                        drop_q;
  logic                        out_valid_q;
  logic                        out_found_q;
  logic [ust_pkg::COUNT_W-1:0] out_count_q;
  logic                        out_dropped_q;

  logic                                    match;
  logic                                    last_cmp;
  logic                                    full;
  logic                                    issue;
  logic [CNT_W-1:0]                        cnt_m1;
  logic                                    re;
  logic [IDX_W-1:0]                        raddr;
  logic                                    we;
  logic [IDX_W-1:0]                        waddr;
  logic [ust_pkg::VALUE_W-1:0]             wdata;
  logic [CNT_W+ust_pkg::COUNT_W-1:0]       cnt_ext;

  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign full     = (cnt_q == CNT_W'(CAPACITY));
  assign match    = cmp_vld_q && (rdata_q == val_q);
  assign last_cmp = cmp_vld_q && (CNT_W'(cmp_idx_q) == cnt_m1);
  assign issue    = cmd_i.scan && !match && (idx_q < cnt_q);

  assign sts_o.match    = match;
  assign sts_o.scan_end = !match && ((cnt_q == '0) || last_cmp);
  assign sts_o.op       = op_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // one read port: scan walk or last-entry fetch
  assign re    = issue || cmd_i.read_last;
  assign raddr = cmd_i.read_last ? cnt_m1[IDX_W-1:0] : idx_q[IDX_W-1:0];

  // one write port: append at end or fill the deleted slot
  assign we    = (cmd_i.append && !full) || cmd_i.move;
  assign waddr = cmd_i.move ? slot_q : cnt_q[IDX_W-1:0];
  assign wdata = cmd_i.move ? rdata_q : val_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q     <= '0;
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
        drop_q    <= 1'b0;
      end else if (cmd_i.scan) begin
        if (match) begin
          hit_q     <= 1'b1;
          cmp_vld_q <= 1'b0;
        end else begin
          cmp_vld_q <= issue;
          if (issue) begin
            idx_q <= idx_q + CNT_W'(1);
          end
        end
      end
      if (cmd_i.append) begin
        if (full) begin
          drop_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.move) begin
        cnt_q <= cnt_m1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cnt_ext = {{ust_pkg::COUNT_W{1'b0}}, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_func_i;
      val_q <= $unsigned(in_value_i);
    end
    if (issue) begin
      cmp_idx_q <= idx_q[IDX_W-1:0];
    end
    if (cmd_i.scan && match) begin
      slot_q <= cmp_idx_q;
    end
    if (cmd_i.emit) begin
      out_found_q   <= hit_q;
      out_count_q   <= cnt_ext[ust_pkg::COUNT_W-1:0];
      out_dropped_q <= drop_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_found_o   = out_found_q;
  assign out_count_o   = out_count_q;
  assign out_dropped_o = out_dropped_q;

endmodule

FILE: rtl/unordered_set_table_core.sv
// Unordered set of 32-bit values kept in a single-port-read element memory.
// req_i: func (insert, delete, membership query; code 3 acts as a query)
// and value. rsp_o: one result per request with found (value present before
// the operation), count (entries after it) and dropped (insert refused
// because the store holds CAPACITY entries).
// The stored entries are compared one per cycle through the memory's
// registered read port, and a scan stops at the first hit; a delete hit
// then fetches the last entry and writes it into the freed slot.
// One request is worked on at a time; req_i.ready is high only while idle.
// The result sits in an output register, so a new request is taken while a
// result still waits; if rsp_o is stalled, the next result holds in the
// controller until the register frees.
// Reset empties the set (count 0); memory contents need no clearing since
// only entries below count are ever read.
module unordered_set_table_core #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ust_req_if.sink     req_i,
  ust_rsp_if.source   rsp_o
);

  ust_pkg::ust_cmd_t cmd;
  ust_pkg::ust_sts_t sts;

  ust_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ust_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_func_i     (req_i.func),
    .in_value_i    (req_i.value),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .out_found_o   (rsp_o.found),
    .out_count_o   (rsp_o.count),
    .out_dropped_o (rsp_o.dropped)
  );

`ifndef NO_ASSERTIONS
  // busy after a request transfer until its result is emitted
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while previous one in progress");

  // a compare hit can only show up while scanning
  a_match_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.match |-> cmd.scan)
    else $error("match outside scan");

  // never overwrite a result that has not been transferred
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!rsp_o.valid || rsp_o.ready))
    else $error("result register overwritten");
`endif

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FUNC_W  = ust_pkg::FUNC_W;
  localparam int unsigned VALUE_W = ust_pkg::VALUE_W;
  localparam int unsigned COUNT_W = ust_pkg::COUNT_W;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = ust_pkg::FUNC_INSERT;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = ust_pkg::FUNC_DELETE;
  localparam logic [FUNC_W-1:0] FUNC_MEMBER = ust_pkg::FUNC_MEMBER;

  localparam int unsigned CAP = 1024;
  localparam int unsigned POOL_N = 64;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  // odd multiplier: i * FILL_MULT is a bijection on 32 bits
  localparam logic [VALUE_W-1:0] FILL_MULT = 32'h9E37_79B1;
  localparam logic [VALUE_W-1:0] FILL_XOR = 32'h0F0F_0000;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] count;
    logic               dropped;
  } set_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ust_req_if req_if ();
  ust_rsp_if rsp_if ();

  unordered_set_table_core #(
    .CAPACITY(CAP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the set
  logic [VALUE_W-1:0] elem_mem [CAP];
  int unsigned        elem_cnt;

  set_result_t result_q [$];
  int          err_cnt;
  bit          idle_on;
  int          holdoff_left;
  int          stall_left;
  logic [VALUE_W-1:0] pool [POOL_N];

  function automatic set_result_t apply_set_op(input logic [FUNC_W-1:0] func,
                                               input logic [VALUE_W-1:0] value);
    set_result_t res;
    int unsigned slot;
    logic        hit;
    slot = elem_cnt;
    hit  = 1'b0;
    for (int unsigned k = 0; k < elem_cnt; k++) begin
      if (elem_mem[k] == value) begin
        slot = k;
        hit  = 1'b1;
        break;
      end
    end
    res.dropped = 1'b0;
    case (func)
      FUNC_INSERT: begin
        if (!hit) begin
          if (elem_cnt < CAP) begin
            elem_mem[elem_cnt] = value;
            elem_cnt++;
          end else begin
            res.dropped = 1'b1;
          end
        end
      end
      FUNC_DELETE: begin
        // last entry fills the freed slot
        if (hit) begin
          elem_mem[slot] = elem_mem[elem_cnt-1];
          elem_cnt--;
        end
      end
      default: ;
    endcase
    res.found = hit;
    res.count = COUNT_W'(elem_cnt);
    return res;
  endfunction

  // mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  task automatic send_op(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value);
    @(negedge clk_i);
    if (idle_on && $urandom_range(99) < 25) begin
      req_if.valid = 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.func  = func;
    req_if.value = value;
    do @(posedge clk_i); while (!req_if.ready);
    result_q.push_back(apply_set_op(func, value));
  endtask

  task automatic release_req();
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  task automatic wait_drain();
    release_req();
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  // deleting whatever sits in slot 0 hits on the first compare
  task automatic clear_set();
    while (elem_cnt > 0) send_op(FUNC_DELETE, elem_mem[0]);
  endtask

  task automatic test_empty_set();
    send_op(FUNC_MEMBER, 32'h0000_0000);
    send_op(FUNC_DELETE, 32'h0000_0005);
    send_op(FUNC_UNUSED, 32'h0000_0007);
    wait_drain();
  endtask

  task automatic test_directed_ops();
    send_op(FUNC_INSERT, 32'h8000_0000);
    send_op(FUNC_INSERT, 32'h7FFF_FFFF);
    send_op(FUNC_INSERT, 32'h0000_0000);
    send_op(FUNC_INSERT, 32'hFFFF_FFFF);
    send_op(FUNC_INSERT, 32'h5555_5555);
    send_op(FUNC_INSERT, 32'hAAAA_AAAA);
    send_op(FUNC_INSERT, 32'h7FFF_FFFF);  // already present
    send_op(FUNC_MEMBER, 32'hFFFF_FFFF);
    send_op(FUNC_UNUSED, 32'hAAAA_AAAA);
    send_op(FUNC_MEMBER, 32'h0001_2345);
    send_op(FUNC_DELETE, 32'h0001_2345);  // absent
    send_op(FUNC_DELETE, 32'h0000_0000);  // middle slot, last moves in
    send_op(FUNC_MEMBER, 32'hAAAA_AAAA);
    send_op(FUNC_DELETE, 32'hAAAA_AAAA);
    send_op(FUNC_DELETE, 32'h8000_0000);  // first slot
    send_op(FUNC_MEMBER, 32'h8000_0000);
    send_op(FUNC_INSERT, 32'h8000_0000);
    send_op(FUNC_DELETE, elem_mem[elem_cnt-1]);  // last slot
    wait_drain();
  endtask

  task automatic test_full_store();
    logic [VALUE_W-1:0] v;
    clear_set();
    for (int unsigned i = 0; i < CAP; i++) begin
      v = (VALUE_W'(i) * FILL_MULT) ^ FILL_XOR;
      send_op(FUNC_INSERT, v);
    end
    send_op(FUNC_INSERT, (VALUE_W'(CAP) * FILL_MULT) ^ FILL_XOR);  // refused
    send_op(FUNC_INSERT, elem_mem[CAP-1]);
    send_op(FUNC_MEMBER, elem_mem[CAP-1]);
    send_op(FUNC_UNUSED, (VALUE_W'(CAP + 1) * FILL_MULT) ^ FILL_XOR);
    send_op(FUNC_DELETE, (VALUE_W'(CAP + 1) * FILL_MULT) ^ FILL_XOR);
    send_op(FUNC_DELETE, elem_mem[CAP/2]);
    send_op(FUNC_INSERT, (VALUE_W'(CAP) * FILL_MULT) ^ FILL_XOR);
    send_op(FUNC_INSERT, (VALUE_W'(CAP + 1) * FILL_MULT) ^ FILL_XOR);  // refused
    wait_drain();
  endtask

  task automatic test_backpressure();
    bit saved_idle;
    saved_idle = idle_on;
    idle_on = 1'b0;
    release_req();
    @(posedge clk_i);
    holdoff_left = 300;
    for (int i = 0; i < 12; i++) begin
      send_op((i % 3 == 2) ? FUNC_MEMBER : FUNC_INSERT, $urandom());
    end
    wait_drain();
    idle_on = saved_idle;
  endtask

  task automatic test_random_ops();
    int r;
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    pool[2] = 32'h8000_0000;
    pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_N; i++) pool[i] = $urandom();
    for (int n = 0; n < 580; n++) begin
      if (n % 60 == 0) idle_on = ($urandom_range(3) != 0);
      r = $urandom_range(99);
      if (r < 45) func = FUNC_INSERT;
      else if (r < 75) func = FUNC_DELETE;
      else if (r < 93) func = FUNC_MEMBER;
      else func = FUNC_UNUSED;
      if ($urandom_range(9) != 0) value = pool[$urandom_range(POOL_N-1)];
      else value = $urandom();
      send_op(func, value);
    end
    wait_drain();
  endtask

  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (result_q.size() == 0) begin
        $error("result transfer with nothing outstanding");
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        if (rsp_if.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, rsp_if.found);
          err_cnt++;
        end
        if (rsp_if.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp_if.count);
          err_cnt++;
        end
        if (rsp_if.dropped !== want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, rsp_if.dropped);
          err_cnt++;
        end
      end
    end
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    rsp_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_left > 0) begin
        rsp_if.ready = 1'b0;
        holdoff_left--;
      end else if (stall_left > 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(99) < 20) begin
        rsp_if.ready = 1'b0;
        stall_left = gap_len() - 1;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  initial begin
    #150ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.func   = FUNC_INSERT;
    req_if.value  = '0;
    err_cnt       = 0;
    elem_cnt      = 0;
    idle_on       = 1'b1;
    holdoff_left  = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_set();
    test_directed_ops();
    test_backpressure();
    test_random_ops();
    test_full_store();

    wait_drain();
    repeat (CAP + 16) @(posedge clk_i);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
